FILE: src/nsp_pkg.sv
// Shared widths, constants, types and arctangent table for the wrapped-phase block.
package nsp_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int PHASE_W      = 17;
   localparam int NUM_W        = 19;
   localparam int DEN_W        = 17;
   localparam int FRAC_SHIFT   = 24;
   localparam int XY_W         = 44;
   localparam int Z_W          = 34;
   localparam int T_W          = 35;
   localparam int ATAN_STEPS   = 24;
   localparam int ATAN_W       = 32;
   localparam int STEP_COUNT_W = 3;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [STEP_COUNT_W-1:0] STEP_COUNT_RESET = 3'd4;
   localparam logic [STEP_COUNT_W-1:0] STEP_COUNT_THREE = 3'd3;

   localparam logic CSR_IDX_STEP_COUNT = 1'b0;

   localparam logic [PHASE_W-1:0] PHASE_PI     = 17'd32768;
   localparam logic [PHASE_W-1:0] PHASE_TWO_PI = 17'd65536;

   localparam logic signed [Z_W-1:0] Z_HALF_TURN  = 34'sh0_8000_0000;
   localparam logic signed [T_W-1:0] T_ROUND_BIAS = 35'sh0_8000_8000;

   localparam logic [ATAN_W-1:0] ATAN_TABLE [0:ATAN_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   forced;
      logic [PHASE_W-1:0]     forced_phase;
   } nsp_vec_type;

endpackage

FILE: src/nsp_req_if.sv
// Input channel: four phase-shifted samples of one pixel with valid/ready.
interface nsp_req_if import nsp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_a;
   logic signed [SAMPLE_W-1:0] sample_b;
   logic signed [SAMPLE_W-1:0] sample_c;
   logic signed [SAMPLE_W-1:0] sample_d;

   modport source (output valid, sample_a, sample_b, sample_c, sample_d, input ready);
   modport sink   (input valid, sample_a, sample_b, sample_c, sample_d, output ready);
endinterface

FILE: src/nsp_rsp_if.sv
// Result channel: wrapped phase of one pixel with valid/ready.
interface nsp_rsp_if import nsp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] wrapped_phase;

   modport source (output valid, wrapped_phase, input ready);
   modport sink   (input valid, wrapped_phase, output ready);
endinterface

FILE: src/n_step_wrapped_phase.sv
// Top level of the per-pixel wrapped-phase pipeline with its register port.
//
// Usage: each item on req_chan carries four signed 16-bit intensities of one
// pixel; rsp_chan returns one 17-bit wrapped phase per item, in units of
// 2*pi/65536 (0..65536), in input order. Both channels move an item when
// valid and ready are high at a rising clock edge.
// step_count at byte address 0 selects three-step mode when 3, else four-step.
// Write it only while no item is in flight.
// Pipeline: CORDIC_ITERATIONS + 2 register stages lie between an accepted
// item and its result (one difference stage, one stage per CORDIC iteration,
// one rounding stage); iterations cap at 24.
// Throughput: one item per cycle while rsp_chan.ready is high; each CORDIC
// iteration is its own stage. Each stage takes a new item when empty or when
// its output moves on, so bubbles close up while the receiver stalls; no item
// is dropped or repeated. When rsp_chan.ready is low and every stage is full,
// req_chan.ready drops. Reset (synchronous, active high) empties the pipeline
// and sets step_count to 4.
module n_step_wrapped_phase import nsp_pkg::*; #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   nsp_req_if.sink               req_chan,
   nsp_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ROTATIONS =
      (CORDIC_ITERATIONS < ATAN_STEPS) ? CORDIC_ITERATIONS : ATAN_STEPS;

   logic [STEP_COUNT_W-1:0] step_count_ff;
   logic                    csr_write;
   logic                    csr_hit;

   nsp_vec_type stage_vec   [0:ROTATIONS];
   logic        stage_valid [0:ROTATIONS];
   logic        stage_ready [0:ROTATIONS];

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_STEP_COUNT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(step_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= STEP_COUNT_RESET;
      end else if (csr_write && csr_hit) begin
         step_count_ff <= csr_pwdata[STEP_COUNT_W-1:0];
      end
   end

   nsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .step_count (step_count_ff),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .sample_a   (req_chan.sample_a),
      .sample_b   (req_chan.sample_b),
      .sample_c   (req_chan.sample_c),
      .sample_d   (req_chan.sample_d),
      .out_valid  (stage_valid[0]),
      .out_ready  (stage_ready[0]),
      .out_vec    (stage_vec[0])
   );

   for (genvar i = 0; i < ROTATIONS; i++) begin : g_cordic
      nsp_cordic_stage #(
         .STEP_INDEX (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_vec    (stage_vec[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_vec   (stage_vec[i+1])
      );
   end

   nsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[ROTATIONS]),
      .in_ready  (stage_ready[ROTATIONS]),
      .in_vec    (stage_vec[ROTATIONS]),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_phase (rsp_chan.wrapped_phase)
   );

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.wrapped_phase <= PHASE_TWO_PI))
      else $error("wrapped phase above full turn");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("input stalled while result side is ready");

   a_step_count_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_hit) |=> (step_count_ff == $past(csr_pwdata[STEP_COUNT_W-1:0])))
      else $error("step_count write lost");

   a_step_count_reset: assert property (@(posedge clock)
      $past(reset) |-> (step_count_ff == STEP_COUNT_RESET))
      else $error("step_count not at reset value");

endmodule

FILE: src/nsp_front.sv
// Front stage: sample differences, mode select and half-plane pre-rotation.
module nsp_front import nsp_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [STEP_COUNT_W-1:0]    step_count,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [SAMPLE_W-1:0] sample_a,
   input  logic signed [SAMPLE_W-1:0] sample_b,
   input  logic signed [SAMPLE_W-1:0] sample_c,
   input  logic signed [SAMPLE_W-1:0] sample_d,
   output logic                       out_valid,
   input  logic                       out_ready,
   output nsp_vec_type                out_vec
);

   logic                    valid_ff;
   nsp_vec_type             vec_ff;
   nsp_vec_type             vec_in;
   logic signed [NUM_W-1:0] num4;
   logic signed [NUM_W-1:0] num3;
   logic signed [NUM_W-1:0] num;
   logic signed [NUM_W-1:0] y_base;
   logic signed [DEN_W-1:0] den4;
   logic signed [DEN_W-1:0] den3;
   logic signed [DEN_W-1:0] den;
   logic signed [DEN_W-1:0] x_base;
   logic                    den_neg;
   logic                    three_step;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   always_comb begin
      three_step = (step_count == STEP_COUNT_THREE);
      num4 = NUM_W'(sample_d) - NUM_W'(sample_b);
      den4 = DEN_W'(sample_a) - DEN_W'(sample_c);
      num3 = (NUM_W'(sample_b) <<< 1) - NUM_W'(sample_a) - NUM_W'(sample_c);
      den3 = DEN_W'(sample_c) - DEN_W'(sample_a);
      num  = three_step ? num3 : num4;
      den  = three_step ? den3 : den4;
      den_neg = den[DEN_W-1];
      x_base  = den_neg ? -den : den;
      y_base  = den_neg ? -num : num;
      vec_in.x = {{(XY_W-DEN_W-FRAC_SHIFT){x_base[DEN_W-1]}}, x_base, {FRAC_SHIFT{1'b0}}};
      vec_in.y = {{(XY_W-NUM_W-FRAC_SHIFT){y_base[NUM_W-1]}}, y_base, {FRAC_SHIFT{1'b0}}};
      if (!den_neg) begin
         vec_in.z = '0;
      end else if (num[NUM_W-1]) begin
         vec_in.z = -Z_HALF_TURN;
      end else begin
         vec_in.z = Z_HALF_TURN;
      end
      vec_in.forced       = (num == '0);
      vec_in.forced_phase = den_neg ? PHASE_TWO_PI : PHASE_PI;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule

FILE: src/nsp_cordic_stage.sv
// One vectoring CORDIC iteration as a registered pipeline stage.
module nsp_cordic_stage import nsp_pkg::*; #(
   parameter int STEP_INDEX = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  nsp_vec_type in_vec,
   output logic        out_valid,
   input  logic        out_ready,
   output nsp_vec_type out_vec
);

   logic                   valid_ff;
   nsp_vec_type            vec_ff;
   nsp_vec_type            vec_in;
   logic signed [XY_W-1:0] x_cur;
   logic signed [XY_W-1:0] y_cur;
   logic signed [XY_W-1:0] x_shift;
   logic signed [XY_W-1:0] y_shift;
   logic signed [Z_W-1:0]  atan_step;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   assign atan_step = {{(Z_W-ATAN_W){1'b0}}, ATAN_TABLE[STEP_INDEX]};

   always_comb begin
      x_cur   = in_vec.x;
      y_cur   = in_vec.y;
      x_shift = x_cur >>> STEP_INDEX;
      y_shift = y_cur >>> STEP_INDEX;
      vec_in  = in_vec;
      if (!y_cur[XY_W-1]) begin
         vec_in.x = x_cur + y_shift;
         vec_in.y = y_cur - x_shift;
         vec_in.z = in_vec.z + atan_step;
      end else begin
         vec_in.x = x_cur - y_shift;
         vec_in.y = y_cur + x_shift;
         vec_in.z = in_vec.z - atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

endmodule

FILE: src/nsp_back.sv
// Back stage: angle to phase rounding, clamp and special-case override.
module nsp_back import nsp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  nsp_vec_type        in_vec,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [PHASE_W-1:0] out_phase
);

   logic                        valid_ff;
   logic [PHASE_W-1:0]          phase_ff;
   logic [PHASE_W-1:0]          phase_in;
   logic signed [T_W-1:0]       t_sum;
   logic [T_W-2-PHASE_W+1:0]    t_high;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_phase = phase_ff;

   always_comb begin
      t_sum  = T_W'(in_vec.z) + T_ROUND_BIAS;
      t_high = t_sum[T_W-2:PHASE_W-1];
      if (in_vec.forced) begin
         phase_in = in_vec.forced_phase;
      end else if (t_sum[T_W-1]) begin
         phase_in = '0;
      end else if (t_high > {1'b0, PHASE_TWO_PI}) begin
         phase_in = PHASE_TWO_PI;
      end else begin
         phase_in = t_high[PHASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         phase_ff <= phase_in;
      end
   end

endmodule
